FILE: rtl/char_lcd_nibble_writer_macros.svh
// ----------------------------------------------------------------------------
// char_lcd_nibble_writer assertion macros
// shared concurrent assertion forms, clocked on clk with synchronous rst
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_NIBBLE_WRITER_MACROS_SVH
`define CHAR_LCD_NIBBLE_WRITER_MACROS_SVH

// same-cycle implication
`define CLNW_ASSERT_SAME(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed: same-cycle check");

// next-cycle implication
`define CLNW_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed: next-cycle check");

`endif

FILE: rtl/clnw_pkg.sv
// ----------------------------------------------------------------------------
// clnw_pkg
// shared types and constants of the character lcd nibble writer
// ----------------------------------------------------------------------------
package clnw_pkg;

  // field widths
  localparam int MODE_W     = 3;
  localparam int CODE_W     = 8;
  localparam int NIB_W      = 4;
  localparam int COL_W      = 6;
  localparam int LINES_W    = 3;
  localparam int ADDR_W     = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;
  localparam int OUT_DATA_W = 8;

  localparam int DEFAULT_MAX_LINES = 4;

  // input modes
  localparam logic [MODE_W-1:0] MODE_TEXT     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_RAW_CMD  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_RAW_DATA = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CLEAR    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_RESET    = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CHARS_PER_LINE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_COUNT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_ADDR_0    = 3'd2;

  // command and character codes
  localparam logic [CODE_W-1:0] CMD_CLEAR     = 8'h01;
  localparam logic [CODE_W-1:0] CMD_SET_ADDR  = 8'h80;
  localparam logic [CODE_W-1:0] NEWLINE_CODE  = 8'h0A;
  // wake-up sequence 3,3,3,2 packed as two command bytes
  localparam logic [CODE_W-1:0] WAKE_BYTE_HI  = 8'h33;
  localparam logic [CODE_W-1:0] WAKE_BYTE_LO  = 8'h32;

  // register-select values
  localparam logic RS_CMD  = 1'b0;
  localparam logic RS_DATA = 1'b1;

  // one queued job: one or two bytes, each with its register select
  typedef struct packed {
    logic [CODE_W-1:0] byte0;
    logic              rs0;
    logic [CODE_W-1:0] byte1;
    logic              rs1;
    logic              two;
  } job_t;

  // front-end counters, exported for checking
  typedef struct packed {
    logic [COL_W-1:0]   column_pos;
    logic [LINES_W-1:0] line_moves;
  } front_stat_t;

endpackage

FILE: rtl/char_lcd_nibble_writer.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_writer
// turns text, command and control requests into 4-bit lcd bus writes
// ----------------------------------------------------------------------------
//  channel   dir  handshake                 payload
//  s_axis    in   s_axis_tvalid/tready      tdata: char_code, tuser: mode
//  m_axis    out  m_axis_tvalid/tready      tdata: nibble, tuser: reg_select,
//                                           tlast: last
//  cfg       in   cfg_valid/cfg_ready       cfg_index, cfg_data
//
//  each request leaves as 0, 2 or 4 nibbles, one per cycle from the output
//  register while m_axis is ready; a stream of 4-nibble requests is paced
//  by the single nibble bus
//  requests are taken every cycle while the two-entry job queue has room
//  rst is synchronous; counters and configuration clear to zero
//  a stalled m_axis holds its nibble; s_axis stalls only when the queue fills
//  cfg_ready is always high
// ----------------------------------------------------------------------------
module char_lcd_nibble_writer #(
  parameter int MAX_LINES = clnw_pkg::DEFAULT_MAX_LINES
) (
  input  logic                            clk,
  input  logic                            rst,
  // input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [clnw_pkg::CODE_W-1:0]     s_axis_tdata,  // [7:0] char_code
  input  logic [clnw_pkg::MODE_W-1:0]     s_axis_tuser,  // [2:0] mode
  // output stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [clnw_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // [3:0] nibble, [7:4] zero
  output logic                            m_axis_tuser,  // [0] reg_select
  output logic                            m_axis_tlast,
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [clnw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [clnw_pkg::CFG_DATA_W-1:0] cfg_data
);
  import clnw_pkg::*;

  `include "char_lcd_nibble_writer_macros.svh"

  logic         in_fire;
  logic         push;
  job_t         push_job;
  front_stat_t  stat;
  logic         q_full;
  logic         q_valid;
  job_t         q_head;
  logic         q_pop;
  logic [NIB_W-1:0] nibble;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = ~q_full;
  assign in_fire       = s_axis_tvalid & s_axis_tready;

  // front end
  clnw_front #(
    .MAX_LINES (MAX_LINES)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .in_fire (in_fire),
    .in_mode (s_axis_tuser),
    .in_code (s_axis_tdata),
    .cfg_we  (cfg_valid & cfg_ready),
    .cfg_idx (cfg_index),
    .cfg_val (cfg_data),
    .push    (push),
    .job     (push_job),
    .stat    (stat)
  );

  // job queue
  clnw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (q_head)
  );

  // nibble sequencer
  clnw_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_nibble (nibble),
    .out_rs     (m_axis_tuser),
    .out_last   (m_axis_tlast)
  );

  assign m_axis_tdata = {{(OUT_DATA_W-NIB_W){1'b0}}, nibble};

  // checks
  `CLNW_ASSERT_SAME(a_no_push_when_full, push, !q_full)
  `CLNW_ASSERT_NEXT(a_clear_resets_counters, in_fire && s_axis_tuser == MODE_CLEAR, stat.column_pos == '0 && stat.line_moves == '0)
  `CLNW_ASSERT_NEXT(a_job_nibbles_back_to_back, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid)

endmodule

FILE: rtl/clnw_front.sv
// ----------------------------------------------------------------------------
// clnw_front
// accepts items, holds configuration and counters, classifies into jobs
// ----------------------------------------------------------------------------
module clnw_front #(
  parameter int MAX_LINES = clnw_pkg::DEFAULT_MAX_LINES
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_fire,
  input  logic [clnw_pkg::MODE_W-1:0]    in_mode,
  input  logic [clnw_pkg::CODE_W-1:0]    in_code,
  input  logic                           cfg_we,
  input  logic [clnw_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [clnw_pkg::CFG_DATA_W-1:0] cfg_val,
  output logic                           push,
  output clnw_pkg::job_t                 job,
  output clnw_pkg::front_stat_t          stat
);
  import clnw_pkg::*;

  localparam int SEL_W = (MAX_LINES > 2) ? 2 : 1;

  logic [COL_W-1:0]   chars_per_line;
  logic [LINES_W-1:0] line_count;
  logic [ADDR_W-1:0]  line_addr [0:MAX_LINES-1];
  logic [COL_W-1:0]   column_pos, column_pos_next;
  logic [LINES_W-1:0] line_moves, line_moves_next;

  logic [LINES_W-1:0] lines_in_use;
  logic               can_move;
  logic [CODE_W-1:0]  move_byte;
  logic [COL_W-1:0]   col_base;
  logic               push_int;

  // table entries left for a line move
  assign lines_in_use = (line_count > LINES_W'(MAX_LINES)) ? LINES_W'(MAX_LINES) : line_count;
  assign can_move     = line_moves < lines_in_use;
  assign move_byte    = CMD_SET_ADDR | {1'b0, line_addr[line_moves[SEL_W-1:0]]};

  // classify the item and work out counter updates
  always_comb begin
    column_pos_next = column_pos;
    line_moves_next = line_moves;
    col_base        = column_pos;
    push_int        = 1'b0;
    job             = '0;
    case (in_mode)
      MODE_TEXT: begin
        if (line_count != '0 && in_code == NEWLINE_CODE) begin
          if (can_move) begin
            push_int        = 1'b1;
            job.byte0       = move_byte;
            job.rs0         = RS_CMD;
            line_moves_next = line_moves + 1'b1;
            column_pos_next = '0;
          end
        end else begin
          push_int = 1'b1;
          if (chars_per_line != '0 && column_pos >= chars_per_line && can_move) begin
            job.byte0       = move_byte;
            job.rs0         = RS_CMD;
            job.byte1       = in_code;
            job.rs1         = RS_DATA;
            job.two         = 1'b1;
            line_moves_next = line_moves + 1'b1;
            col_base        = '0;
          end else begin
            job.byte0 = in_code;
            job.rs0   = RS_DATA;
          end
          // column count saturates at the line length
          if (chars_per_line != '0 && col_base < chars_per_line) begin
            column_pos_next = col_base + 1'b1;
          end else begin
            column_pos_next = col_base;
          end
        end
      end
      MODE_RAW_CMD: begin
        push_int  = 1'b1;
        job.byte0 = in_code;
        job.rs0   = RS_CMD;
      end
      MODE_RAW_DATA: begin
        push_int  = 1'b1;
        job.byte0 = in_code;
        job.rs0   = RS_DATA;
      end
      MODE_CLEAR: begin
        push_int        = 1'b1;
        job.byte0       = CMD_CLEAR;
        job.rs0         = RS_CMD;
        column_pos_next = '0;
        line_moves_next = '0;
      end
      MODE_RESET: begin
        push_int  = 1'b1;
        job.byte0 = WAKE_BYTE_HI;
        job.rs0   = RS_CMD;
        job.byte1 = WAKE_BYTE_LO;
        job.rs1   = RS_CMD;
        job.two   = 1'b1;
      end
      default: begin
        push_int = 1'b0;
      end
    endcase
  end

  assign push = in_fire & push_int;
  assign stat = '{column_pos: column_pos, line_moves: line_moves};

  // counters
  always_ff @(posedge clk) begin
    if (rst) begin
      column_pos <= '0;
      line_moves <= '0;
    end else if (in_fire) begin
      column_pos <= column_pos_next;
      line_moves <= line_moves_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      chars_per_line <= '0;
      line_count     <= '0;
    end else if (cfg_we) begin
      if (cfg_idx == CFG_CHARS_PER_LINE) begin
        chars_per_line <= cfg_val[COL_W-1:0];
      end
      if (cfg_idx == CFG_LINE_COUNT) begin
        line_count <= cfg_val[LINES_W-1:0];
      end
    end
  end

  // line address table
  for (genvar k = 0; k < MAX_LINES; k++) begin : g_addr
    always_ff @(posedge clk) begin
      if (rst) begin
        line_addr[k] <= '0;
      end else if (cfg_we && cfg_idx == CFG_IDX_W'(CFG_LINE_ADDR_0 + k)) begin
        line_addr[k] <= cfg_val[ADDR_W-1:0];
      end
    end
  end

endmodule

FILE: rtl/clnw_queue.sv
// ----------------------------------------------------------------------------
// clnw_queue
// two-entry job queue between front end and nibble sequencer
// ----------------------------------------------------------------------------
module clnw_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  clnw_pkg::job_t push_job,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output clnw_pkg::job_t head
);
  import clnw_pkg::*;

  job_t       slots [0:1];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = count == 2'd2;
  assign not_empty = count != 2'd0;
  assign head      = slots[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // payload slots
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

FILE: rtl/clnw_back.sv
// ----------------------------------------------------------------------------
// clnw_back
// nibble sequencer: splits jobs into bus nibbles behind an output register
// ----------------------------------------------------------------------------
module clnw_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  input  clnw_pkg::job_t              q_head,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [clnw_pkg::NIB_W-1:0]  out_nibble,
  output logic                        out_rs,
  output logic                        out_last
);
  import clnw_pkg::*;

  job_t             cur;
  logic             cur_valid;
  logic [1:0]       idx;

  job_t             src;
  logic [1:0]       src_idx;
  logic             avail;
  logic             load;
  logic [CODE_W-1:0] src_byte;
  logic [NIB_W-1:0] src_nib;
  logic             src_rs;
  logic             src_last;

  // next nibble comes from the job in progress, else the queue head
  assign src      = cur_valid ? cur : q_head;
  assign src_idx  = cur_valid ? idx : 2'd0;
  assign avail    = cur_valid | q_valid;
  assign load     = ~out_valid | out_ready;
  assign q_pop    = load & ~cur_valid & q_valid;

  // high nibble first, first byte first
  assign src_byte = src_idx[1] ? src.byte1 : src.byte0;
  assign src_nib  = src_idx[0] ? src_byte[NIB_W-1:0] : src_byte[CODE_W-1:NIB_W];
  assign src_rs   = src_idx[1] ? src.rs1 : src.rs0;
  assign src_last = src_idx == (src.two ? 2'd3 : 2'd1);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cur_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (load) begin
      out_valid <= avail;
      if (avail) begin
        if (src_last) begin
          cur_valid <= 1'b0;
        end else begin
          cur_valid <= 1'b1;
          idx       <= src_idx + 2'd1;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load && avail) begin
      out_nibble <= src_nib;
      out_rs     <= src_rs;
      out_last   <= src_last;
      if (!cur_valid) begin
        cur <= q_head;
      end
    end
  end

endmodule
